FILE: hw/rtl/wsup_pkg.sv
// ----------------------------------------------------------------------------
// wsup_pkg
// Shared types, constants and character tables for the wide-string to
// unsigned parser.
// ----------------------------------------------------------------------------
package wsup_pkg;

  // Field and state widths.
  localparam int unsigned CU_W   = 16;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned OFS_W  = 13;
  localparam int unsigned ACC_W  = 33;
  localparam int unsigned BASE_W = 6;
  localparam int unsigned DIG_W  = 6;
  localparam int unsigned PROD_W = ACC_W + BASE_W;

  // Offsets saturate at this length.
  localparam int unsigned MAX_LEN = 4096;

  // Configuration port.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;

  // Base limits and the code for a unit that is no digit.
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [DIG_W-1:0]  NO_DIGIT  = 6'd36;

  // The clamp point of the accumulator and the all-ones result.
  localparam logic [ACC_W-1:0] ACC_CLAMP = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] ALL_ONES  = {VAL_W{1'b1}};

  // Character codes.
  localparam logic [CU_W-1:0] CH_PLUS  = 16'h002B;
  localparam logic [CU_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CU_W-1:0] CH_LX    = 16'h0078;
  localparam logic [CU_W-1:0] CH_UX    = 16'h0058;
  localparam logic [CU_W-1:0] CH_LA    = 16'h0061;
  localparam logic [CU_W-1:0] CH_LZ    = 16'h007A;
  localparam logic [CU_W-1:0] CH_UA    = 16'h0041;
  localparam logic [CU_W-1:0] CH_UZ    = 16'h005A;

  // First code of each Unicode block of decimal digits.
  localparam int unsigned N_BLOCKS = 18;
  localparam logic [CU_W-1:0] DIGIT_BLOCKS [N_BLOCKS] = '{
    16'h0030, 16'h0660, 16'h06F0, 16'h0966, 16'h09E6, 16'h0A66, 16'h0AE6,
    16'h0B66, 16'h0C66, 16'h0CE6, 16'h0D66, 16'h0E50, 16'h0ED0, 16'h0F20,
    16'h1040, 16'h17E0, 16'h1810, 16'hFF10};

  // Whitespace codes skipped ahead of the number.
  localparam int unsigned N_SPACES = 26;
  localparam logic [CU_W-1:0] SPACE_CODES [N_SPACES] = '{
    16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020, 16'h0085,
    16'h00A0, 16'h1680, 16'h180E, 16'h2000, 16'h2001, 16'h2002, 16'h2003,
    16'h2004, 16'h2005, 16'h2006, 16'h2007, 16'h2008, 16'h2009, 16'h200A,
    16'h2028, 16'h2029, 16'h202F, 16'h205F, 16'h3000};

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PH_WS     = 7'b0000001,
    PH_SIGN   = 7'b0000010,
    PH_ZERO   = 7'b0000100,
    PH_NEED   = 7'b0001000,
    PH_DIGITS = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_NONE   = 7'b1000000
  } phase_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_BASE  = 2'd3
  } status_t;

  // Classification of one code unit.
  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic             space;
    logic             minus;
    logic             plus;
    logic             ex;
  } unit_class_t;

  // One result item.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [OFS_W-1:0] end_offset;
    status_t          status;
  } result_t;

  // Digit value of a code unit, or NO_DIGIT.
  function automatic logic [DIG_W-1:0] digit_of(input logic [CU_W-1:0] u);
    logic [CU_W-1:0]  d;
    logic [DIG_W-1:0] r;
    logic             hit;
    r   = NO_DIGIT;
    hit = 1'b0;
    for (int i = 0; i < N_BLOCKS; i++) begin
      d = u - DIGIT_BLOCKS[i];
      if (!hit && d <= 16'd9) begin
        r   = d[DIG_W-1:0];
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (u >= CH_LA && u <= CH_LZ) begin
        d = u - CH_LA;
        r = d[DIG_W-1:0] + BASE_DEC;
      end else if (u >= CH_UA && u <= CH_UZ) begin
        d = u - CH_UA;
        r = d[DIG_W-1:0] + BASE_DEC;
      end
    end
    return r;
  endfunction

  // True for one of the whitespace codes.
  function automatic logic is_space(input logic [CU_W-1:0] u);
    logic r;
    r = 1'b0;
    for (int i = 0; i < N_SPACES; i++) begin
      if (u == SPACE_CODES[i]) begin
        r = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/wsup_if.sv
// ----------------------------------------------------------------------------
// wsup_in_if / wsup_out_if
// Valid-ready channels for the code units going in and the results coming out.
// ----------------------------------------------------------------------------
interface wsup_in_if;
  import wsup_pkg::*;

  logic            valid;
  logic            ready;
  logic [CU_W-1:0] code_unit;
  logic            is_last;

  modport source (output valid, output code_unit, output is_last, input ready);
  modport sink   (input valid, input code_unit, input is_last, output ready);
endinterface

interface wsup_out_if;
  import wsup_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic [OFS_W-1:0] end_offset;
  logic [1:0]       status;

  modport source (output valid, output value, output end_offset, output status,
                  input ready);
  modport sink   (input valid, input value, input end_offset, input status,
                  output ready);
endinterface

FILE: hw/rtl/wsup_cfg.sv
// ----------------------------------------------------------------------------
// wsup_cfg
// APB-style register port holding the radix register.
// ----------------------------------------------------------------------------
module wsup_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wsup_pkg::CFG_AW-1:0]   paddr,
  input  logic [wsup_pkg::CFG_DW-1:0]   pwdata,
  output logic [wsup_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output logic [wsup_pkg::BASE_W-1:0]   radix
);
  import wsup_pkg::*;

  logic [BASE_W-1:0] radix_r;
  logic              hit;

  // The radix register is the only one; it answers at byte addresses zero to three.
  assign hit    = (paddr[CFG_AW-1] == 1'b0);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (psel && penable && pwrite && hit) begin
      radix_r <= pwdata[BASE_W-1:0];
    end
  end

  // Read back; unused addresses read as zero.
  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(CFG_DW-BASE_W){1'b0}}, radix_r};
    end
  end

  assign radix = radix_r;

endmodule

FILE: hw/rtl/wsup_class.sv
// ----------------------------------------------------------------------------
// wsup_class
// Classifies one code unit: digit value, whitespace, sign and hex marker.
// ----------------------------------------------------------------------------
module wsup_class (
  input  logic [wsup_pkg::CU_W-1:0] code_unit,
  output wsup_pkg::unit_class_t     cls
);
  import wsup_pkg::*;

  // Table compares against the digit blocks and whitespace codes.
  always_comb begin
    cls.digit = digit_of(code_unit);
    cls.space = is_space(code_unit);
    cls.minus = (code_unit == CH_MINUS);
    cls.plus  = (code_unit == CH_PLUS);
    cls.ex    = (code_unit == CH_LX) || (code_unit == CH_UX);
  end

endmodule

FILE: hw/rtl/wsup_core.sv
// ----------------------------------------------------------------------------
// wsup_core
// Per-string parse state, the one-unit step and the result register.
// ----------------------------------------------------------------------------
module wsup_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  output logic                        item_take,
  input  logic                        item_last,
  input  wsup_pkg::unit_class_t       cls,
  input  logic [wsup_pkg::BASE_W-1:0] radix,
  output logic                        res_valid,
  input  logic                        res_ready,
  output wsup_pkg::result_t           res
);
  import wsup_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;
  logic [OFS_W-1:0]   pos_r, pos_nxt;
  logic [OFS_W-1:0]   stop_r, stop_nxt;
  logic               res_valid_r;
  result_t            res_r, res_nxt;

  logic               bad;
  logic               take;
  logic               acc_en;
  logic [PROD_W-1:0]  prod;
  logic [VAL_W-1:0]   neg_val;

  // An item moves on when the result register is free or being emptied.
  assign item_take = item_valid && (!res_valid_r || res_ready);

  // One step of the parser for the unit in the input register.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    base_nxt  = (pos_r == '0) ? radix : base_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    stop_nxt  = stop_r;
    pos_nxt   = (pos_r < OFS_W'(MAX_LEN)) ? pos_r + 1'b1 : pos_r;
    take      = 1'b1;
    acc_en    = 1'b0;
    prod      = '0;

    bad = (base_nxt != BASE_AUTO) && ((base_nxt < BASE_MIN) || (base_nxt > BASE_MAX));

    if (!bad) begin
      // Leading whitespace and the optional sign.
      if (phase_r == PH_WS) begin
        if (cls.space) begin
          take = 1'b0;
        end else if (cls.minus || cls.plus) begin
          neg_nxt   = cls.minus;
          phase_nxt = PH_SIGN;
          take      = 1'b0;
        end else begin
          phase_nxt = PH_SIGN;
        end
      end

      // A zero in auto or hex base waits for the next unit.
      if (take && phase_nxt == PH_SIGN) begin
        if ((base_nxt == BASE_AUTO || base_nxt == BASE_HEX) && cls.digit == '0) begin
          phase_nxt = PH_ZERO;
          take      = 1'b0;
        end else begin
          if (base_nxt == BASE_AUTO) begin
            base_nxt = BASE_DEC;
          end
          phase_nxt = PH_NEED;
        end
      end

      // After the pending zero: hex prefix or an octal or hex digit string.
      // The pending zero itself leaves the zero accumulator unchanged.
      if (take && phase_nxt == PH_ZERO) begin
        if (cls.ex) begin
          base_nxt  = BASE_HEX;
          phase_nxt = PH_NEED;
          take      = 1'b0;
        end else begin
          if (base_nxt == BASE_AUTO) begin
            base_nxt = BASE_OCT;
          end
          phase_nxt = PH_DIGITS;
        end
      end

      // Digits, or the unit that stops the number.
      if (take && (phase_nxt == PH_NEED || phase_nxt == PH_DIGITS)) begin
        if (cls.digit < base_nxt) begin
          acc_en    = !ovf_r;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = (phase_nxt == PH_DIGITS) ? PH_DONE : PH_NONE;
          stop_nxt  = pos_r;
        end
      end
    end

    // Multiply-add with clamping at two to the 32nd.
    if (acc_en) begin
      prod = PROD_W'(acc_r) * PROD_W'(base_nxt) + PROD_W'(cls.digit);
      if (prod > PROD_W'(ACC_CLAMP)) begin
        acc_nxt = ACC_CLAMP;
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = prod[ACC_W-1:0];
      end
    end

    // Result of the string, used when the unit is the last one.
    neg_val = '0 - acc_nxt[VAL_W-1:0];
    res_nxt.value      = '0;
    res_nxt.end_offset = '0;
    if (bad) begin
      res_nxt.status = ST_BAD_BASE;
    end else if (phase_nxt == PH_ZERO || phase_nxt == PH_DIGITS || phase_nxt == PH_DONE) begin
      res_nxt.end_offset = (phase_nxt == PH_DONE) ? stop_nxt : pos_nxt;
      if (acc_nxt[ACC_W-1]) begin
        res_nxt.value  = ALL_ONES;
        res_nxt.status = ST_OVERFLOW;
      end else begin
        res_nxt.value  = neg_nxt ? neg_val : acc_nxt[VAL_W-1:0];
        res_nxt.status = ST_OK;
      end
    end else begin
      res_nxt.status = ST_NO_DIGITS;
    end
  end

  // Parse state; it returns to its start values after every string.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      neg_r   <= 1'b0;
      base_r  <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      pos_r   <= '0;
      stop_r  <= '0;
    end else if (item_take) begin
      if (item_last) begin
        phase_r <= PH_WS;
        neg_r   <= 1'b0;
        base_r  <= '0;
        acc_r   <= '0;
        ovf_r   <= 1'b0;
        pos_r   <= '0;
        stop_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
        pos_r   <= pos_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (item_take && item_last) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item_last) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: hw/rtl/wide_string_to_unsigned_parser.sv
// ----------------------------------------------------------------------------
// wide_string_to_unsigned_parser
// Streaming UTF-16 string to unsigned 32-bit integer converter.
// ----------------------------------------------------------------------------
// The block takes one UTF-16 code unit per cycle while the result side takes
// its items, and gives one result item on the unit marked last: the value, the
// offset of the first unit not consumed and a status. A unit passes an input
// register and then the step logic (table compares and a 33 by 6 bit
// multiply-add) into the result register; the input register holds while the
// result register is full and not being emptied. The radix register is sampled
// on the first unit of each string.
// ----------------------------------------------------------------------------
module wide_string_to_unsigned_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  wsup_in_if.sink                     in_ch,
  wsup_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsup_pkg::CFG_AW-1:0] paddr,
  input  logic [wsup_pkg::CFG_DW-1:0] pwdata,
  output logic [wsup_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import wsup_pkg::*;

  logic              in_valid_r;
  logic [CU_W-1:0]   in_unit_r;
  logic              in_last_r;
  logic              item_take;
  logic [BASE_W-1:0] radix;
  unit_class_t       cls;
  result_t           res;

  // Input register; it refills in the cycle its item moves on.
  assign in_ch.ready = !in_valid_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_unit_r <= in_ch.code_unit;
      in_last_r <= in_ch.is_last;
    end
  end

  wsup_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radix   (radix)
  );

  wsup_class u_class (
    .code_unit (in_unit_r),
    .cls       (cls)
  );

  wsup_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item_take  (item_take),
    .item_last  (in_last_r),
    .cls        (cls),
    .radix      (radix),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.value      = res.value;
  assign out_ch.end_offset = res.end_offset;
  assign out_ch.status     = res.status;

endmodule

FILE: tb/wide_string_to_unsigned_parser_tb.sv
// ----------------------------------------------------------------------------
// wide_string_to_unsigned_parser_tb
// Drives strings of UTF-16 code units into the parser and predicts each
// result with a cycle-free model of the conversion. Covers the fixed bases,
// auto-detection, signs, Unicode digits and spaces, overflow, bad bases and
// offset saturation. Both channels idle at random, and the radix register is
// rewritten between batches while the block is quiet.
// ----------------------------------------------------------------------------
module wide_string_to_unsigned_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsup_pkg::*;

  localparam logic [CFG_AW-1:0] RADIX_ADDR   = 3'd0;
  localparam logic [CU_W-1:0]   CH_NUL       = 16'h0000;
  localparam logic [CU_W-1:0]   CH_ZERO      = 16'h0030;
  localparam logic [CU_W-1:0]   CH_SPACE     = 16'h0020;
  localparam int unsigned       RANDOM_UNITS = 800;
  localparam int unsigned       DRAIN_CYCLES = 8;
  localparam int unsigned       MISMATCH_SHOWN = 10;
  localparam realtime           WATCHDOG_NS  = 10_000_000;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  wsup_in_if  in_ch();
  wsup_out_if out_ch();

  wide_string_to_unsigned_parser u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the radix register and of the per-string parse state.
  logic [BASE_W-1:0] radix_shadow;
  phase_t            parse_phase;
  logic              parse_negative;
  logic [BASE_W-1:0] parse_base;
  logic [ACC_W-1:0]  parse_acc;
  logic              parse_overflowed;
  logic [OFS_W-1:0]  parse_pos;
  logic [OFS_W-1:0]  parse_stop;

  result_t     awaited_results[$];
  int unsigned mismatch_count;
  int unsigned units_sent;
  int          sink_hold;
  bit          calm;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(WATCHDOG_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Gap length for either side: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MISMATCH_SHOWN) begin
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  // Digit value of a unit: Unicode decimal blocks first, then ASCII letters.
  function automatic logic [DIG_W-1:0] unit_digit(input logic [CU_W-1:0] u);
    logic [CU_W-1:0] off;
    for (int i = 0; i < N_BLOCKS; i++) begin
      off = u - DIGIT_BLOCKS[i];
      if (off <= 16'd9) return off[DIG_W-1:0];
    end
    if (u >= CH_LA && u <= CH_LZ) begin
      off = u - CH_LA + 16'd10;
      return off[DIG_W-1:0];
    end
    if (u >= CH_UA && u <= CH_UZ) begin
      off = u - CH_UA + 16'd10;
      return off[DIG_W-1:0];
    end
    return NO_DIGIT;
  endfunction

  function automatic bit unit_is_space(input logic [CU_W-1:0] u);
    for (int i = 0; i < N_SPACES; i++) begin
      if (u == SPACE_CODES[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clear_parse();
    parse_phase      = PH_WS;
    parse_negative   = 1'b0;
    parse_base       = BASE_AUTO;
    parse_acc        = '0;
    parse_overflowed = 1'b0;
    parse_pos        = '0;
    parse_stop       = '0;
  endtask

  // Multiply-add one digit, clamping the accumulator at 2^32.
  task automatic add_digit(input logic [DIG_W-1:0] d);
    logic [63:0] prod;
    if (parse_overflowed) return;
    prod = 64'(parse_acc) * 64'(parse_base) + 64'(d);
    if (prod > 64'(ACC_CLAMP)) begin
      parse_acc        = ACC_CLAMP;
      parse_overflowed = 1'b1;
    end else begin
      parse_acc = prod[ACC_W-1:0];
    end
  endtask

  // Advance the parse by one accepted unit; the last unit yields a result.
  task automatic advance_parse(input logic [CU_W-1:0] u, input logic last);
    logic [DIG_W-1:0] dv;
    logic [OFS_W-1:0] idx;
    logic             take;
    logic             bad;
    result_t          res;
    if (parse_pos == '0) parse_base = radix_shadow;
    idx = parse_pos;
    if (parse_pos < MAX_LEN) parse_pos++;
    bad = (parse_base != BASE_AUTO) && (parse_base < BASE_MIN || parse_base > BASE_MAX);
    if (!bad) begin
      dv   = unit_digit(u);
      take = 1'b1;
      // Leading spaces and an optional sign.
      if (parse_phase == PH_WS) begin
        if (unit_is_space(u)) begin
          take = 1'b0;
        end else if (u == CH_MINUS || u == CH_PLUS) begin
          parse_negative = (u == CH_MINUS);
          parse_phase    = PH_SIGN;
          take           = 1'b0;
        end else begin
          parse_phase = PH_SIGN;
        end
      end
      // A leading zero may start a hex prefix in auto or hex base.
      if (take && parse_phase == PH_SIGN) begin
        if ((parse_base == BASE_AUTO || parse_base == BASE_HEX) && dv == '0) begin
          parse_phase = PH_ZERO;
          take        = 1'b0;
        end else begin
          if (parse_base == BASE_AUTO) parse_base = BASE_DEC;
          parse_phase = PH_NEED;
        end
      end
      // The unit after a pending zero settles prefix against digit.
      if (take && parse_phase == PH_ZERO) begin
        if (u == CH_LX || u == CH_UX) begin
          parse_base  = BASE_HEX;
          parse_phase = PH_NEED;
          take        = 1'b0;
        end else begin
          if (parse_base == BASE_AUTO) parse_base = BASE_OCT;
          add_digit('0);
          parse_phase = PH_DIGITS;
        end
      end
      // Digit run; the first unit outside the base ends it.
      if (take && (parse_phase == PH_NEED || parse_phase == PH_DIGITS)) begin
        if (dv < parse_base) begin
          add_digit(dv);
          parse_phase = PH_DIGITS;
        end else begin
          parse_phase = (parse_phase == PH_DIGITS) ? PH_DONE : PH_NONE;
          parse_stop  = idx;
        end
      end
    end
    if (!last) return;
    res.value      = '0;
    res.end_offset = '0;
    if (bad) begin
      res.status = ST_BAD_BASE;
    end else if (parse_phase == PH_ZERO || parse_phase == PH_DIGITS ||
                 parse_phase == PH_DONE) begin
      res.end_offset = (parse_phase == PH_DONE) ? parse_stop : parse_pos;
      if (parse_acc > ACC_W'(ALL_ONES)) begin
        res.value  = ALL_ONES;
        res.status = ST_OVERFLOW;
      end else begin
        res.value  = parse_negative ? (VAL_W'(0) - parse_acc[VAL_W-1:0])
                                    : parse_acc[VAL_W-1:0];
        res.status = ST_OK;
      end
    end else begin
      res.status = ST_NO_DIGITS;
    end
    awaited_results.push_back(res);
    clear_parse();
  endtask

  // Send one code unit, after a random gap, and wait for its handshake.
  task automatic send_unit(input logic [CU_W-1:0] u, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.code_unit <= u;
    in_ch.is_last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    advance_parse(u, last);
    units_sent++;
  endtask

  task automatic send_queue(input logic [CU_W-1:0] q[$]);
    foreach (q[i]) send_unit(q[i], i == q.size() - 1);
  endtask

  // ASCII text, marked last on its final character or on a trailing NUL.
  task automatic send_ascii(input string s, input bit with_nul);
    for (int i = 0; i < s.len(); i++) begin
      send_unit(CU_W'(s[i]), !with_nul && i == s.len() - 1);
    end
    if (with_nul) send_unit(CH_NUL, 1'b1);
  endtask

  // Stop sending and wait until every awaited result has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic read_radix();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RADIX_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(radix_shadow)) begin
      flag_mismatch("radix readback", 64'(radix_shadow), 64'(prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the radix with junk in the unused upper bits, then read it back.
  task automatic write_radix(input logic [BASE_W-1:0] r);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RADIX_ADDR;
    pwdata  <= {(CFG_DW - BASE_W)'($urandom), r};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    radix_shadow = r;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    read_radix();
    @(posedge clk);
  endtask

  // One digit of the given value, in a random block or letter case.
  function automatic logic [CU_W-1:0] encode_digit(input int d);
    if (d < 10) begin
      if ($urandom_range(0, 1) == 0) return CH_ZERO + CU_W'(d);
      return DIGIT_BLOCKS[$urandom_range(0, N_BLOCKS - 1)] + CU_W'(d);
    end
    return ($urandom_range(0, 1) == 0 ? CH_LA : CH_UA) + CU_W'(d - 10);
  endfunction

  function automatic logic [BASE_W-1:0] pick_radix();
    logic [BASE_W-1:0] common [6] = '{BASE_AUTO, BASE_MIN, BASE_OCT,
                                      BASE_DEC, BASE_HEX, BASE_MAX};
    if ($urandom_range(0, 4) == 0) return BASE_W'($urandom);
    return common[$urandom_range(0, 5)];
  endfunction

  // A random string: mostly a well-formed number, sometimes pure noise.
  task automatic send_random_string();
    logic [CU_W-1:0] q[$];
    int eff;
    int n;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) q.push_back(CU_W'($urandom));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) q.push_back(SPACE_CODES[$urandom_range(0, N_SPACES - 1)]);
      end
      case ($urandom_range(0, 3))
        0:       q.push_back(CH_PLUS);
        1:       q.push_back(CH_MINUS);
        default: ;
      endcase
      eff = int'(radix_shadow);
      if (radix_shadow == BASE_AUTO) begin
        case ($urandom_range(0, 2))
          0: begin
            q.push_back(CH_ZERO);
            q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            eff = 16;
          end
          1: begin
            q.push_back(CH_ZERO);
            eff = 8;
          end
          default: eff = 10;
        endcase
      end else if (radix_shadow == BASE_HEX && $urandom_range(0, 1) == 0) begin
        q.push_back(CH_ZERO);
        q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      end else if (eff < 2 || eff > 36) begin
        eff = 10;
      end
      // Mostly short numbers; a long run now and then to overflow.
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 36) : $urandom_range(0, 10);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0) q.push_back(CU_W'($urandom));
        else q.push_back(encode_digit($urandom_range(0, eff - 1)));
      end
      case ($urandom_range(0, 7))
        5:       ;
        6: begin
          q.push_back(CU_W'($urandom));
          q.push_back(CH_NUL);
        end
        7:       q.push_back(CU_W'($urandom));
        default: q.push_back(CH_NUL);
      endcase
    end
    if (q.size() == 0) q.push_back(CH_NUL);
    send_queue(q);
  endtask

  // Result side: random stalls, and each result against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with none awaited", 64'd0, 64'(out_ch.value));
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.value !== want.value) begin
          flag_mismatch("value", 64'(want.value), 64'(out_ch.value));
        end
        if (out_ch.end_offset !== want.end_offset) begin
          flag_mismatch("end_offset", 64'(want.end_offset), 64'(out_ch.end_offset));
        end
        if (out_ch.status !== want.status) begin
          flag_mismatch("status", 64'(want.status), 64'(out_ch.status));
        end
      end
    end
    if (sink_hold > 0) begin
      out_ch.ready <= 1'b0;
      sink_hold--;
    end else begin
      out_ch.ready <= 1'b1;
      sink_hold = pick_gap();
    end
  end

  // The radix comes out of reset as decimal.
  task automatic test_reset_radix();
    read_radix();
    send_ascii("123", 1'b1);
    drain_results();
  endtask

  // Decimal overflow, signs, Unicode spaces and digits, empty strings.
  task automatic test_decimal();
    write_radix(BASE_DEC);
    send_ascii("4294967295", 1'b0);
    send_ascii("4294967296", 1'b1);
    send_ascii("-1", 1'b1);
    send_unit(16'h3000, 1'b0);
    send_unit(16'h0009, 1'b0);
    send_ascii("+42z", 1'b1);
    send_unit(16'hFFFF, 1'b1);
    send_ascii("", 1'b1);
    send_unit(16'h0669, 1'b0);
    send_unit(16'hFF19, 1'b0);
    send_unit(16'h17E3, 1'b0);
    send_unit(CH_NUL, 1'b1);
  endtask

  // Auto-detected base: hex prefix, octal zero, bare prefix, pending zero.
  task automatic test_auto_base();
    write_radix(BASE_AUTO);
    send_ascii("0x1F", 1'b1);
    send_ascii("017", 1'b1);
    send_ascii("0x", 1'b1);
    send_ascii("0", 1'b0);
    send_ascii("-0Xffffffff", 1'b1);
    send_ascii("98", 1'b0);
  endtask

  task automatic test_fixed_bases();
    write_radix(BASE_HEX);
    send_ascii("0xAb", 1'b0);
    send_ascii("0g", 1'b1);
    write_radix(BASE_MAX);
    send_ascii("Zz", 1'b1);
    write_radix(BASE_MIN);
    send_ascii("1021", 1'b1);
  endtask

  // Bases outside 2..36 other than auto give a bad-base result.
  task automatic test_bad_base();
    write_radix(6'd1);
    send_ascii("12", 1'b1);
    write_radix(6'd37);
    send_ascii("7", 1'b0);
    write_radix(6'd63);
    send_ascii("9", 1'b1);
  endtask

  // Strings past the length limit: the offset saturates.
  task automatic test_long_strings();
    write_radix(BASE_DEC);
    calm = 1'b1;
    repeat (MAX_LEN + 4) send_unit(CH_SPACE, 1'b0);
    send_ascii("5", 1'b1);
    repeat (MAX_LEN + 4) send_unit(CH_ZERO, 1'b0);
    send_ascii("9", 1'b0);
    calm = 1'b0;
  endtask

  // Batches of random strings, each under a freshly written radix.
  task automatic test_random_strings();
    int unsigned stop_at;
    int          n;
    stop_at = units_sent + RANDOM_UNITS;
    while (units_sent < stop_at) begin
      write_radix(pick_radix());
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(5, 20);
      repeat (n) send_random_string();
    end
    calm = 1'b0;
  endtask

  // Reset, the tests in turn, then the verdict.
  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.code_unit = '0;
    in_ch.is_last   = 1'b0;
    out_ch.ready    = 1'b0;
    sink_hold       = 0;
    calm            = 1'b0;
    mismatch_count  = 0;
    units_sent      = 0;
    radix_shadow    = RADIX_RESET;
    clear_parse();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_radix();
    test_decimal();
    test_auto_base();
    test_fixed_bases();
    test_bad_base();
    test_long_strings();
    test_random_strings();
    drain_results();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/wsup_pkg.sv
hw/rtl/wsup_if.sv
hw/rtl/wsup_cfg.sv
hw/rtl/wsup_class.sv
hw/rtl/wsup_core.sv
hw/rtl/wide_string_to_unsigned_parser.sv
tb/wide_string_to_unsigned_parser_tb.sv
